/* src/csr_pkg.sv */
// Shared constants for the continuous systematic resampler.
// Holds register indexes, field widths, reset values and parameter defaults.
// No dependencies.
`default_nettype none

package csr_pkg;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_PARTICLE_COUNT  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PARTITION_COUNT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_OFFSET_U        = 2'd2;

    // field widths
    localparam int WEIGHT_W = 32;
    localparam int INDEX_W  = 16;
    localparam int FRAC_W   = 17;
    localparam int POINT_W  = 7;
    localparam int SUM_W    = 34;
    localparam int OUT_DATA_W = 40;

    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

    // reset values of the registers
    localparam logic [INDEX_W-1:0] RST_PARTICLE_COUNT  = 16'd2;
    localparam logic [POINT_W-1:0] RST_PARTITION_COUNT = 7'd1;

    // parameter defaults
    localparam int DEF_MAX_POINTS    = 64;
    localparam int DEF_MAX_PARTICLES = 65535;

endpackage

`default_nettype wire

/* src/continuous_systematic_resampler.sv */
// Continuous systematic resampler: streamed weights in, stratified picks out.
// Depends on csr_pkg for constants; one shared multiplier and a radix-2 divider.
//
// Usage:
//   s_tdata carries one Q0.32 weight per beat. For every stratified point
//   (u + j)/M that the running sum passes, one beat leaves on m_tdata with
//   the 1-based particle index and the Q1.16 position inside that weight;
//   m_tlast marks the last beat caused by a weight. The user must write the
//   registers via cfg_we/cfg_addr/cfg_wdata only while idle; the block has no guard.
// Sequence:
//   A weight is accepted in ST_IDLE, passes the shared multiplier in turn for
//   M*prev, M*sum and M*w, then reaches the check state; each emitted point
//   goes through ST_PREP and, when the fraction needs it, ST_SAT and the
//   bit-serial divider before the next check. The divider loop sets the
//   throughput; s_tready is high only between weights.
// Reset:
//   Clears the running sum, point and particle counters, any result held,
//   and loads N = 2, M = 1, u = 0.
// Stall:
//   A result sits in the output register until taken; the sequencer holds
//   the next result and waits while m_tready is low. A new weight is taken
//   while the last result of the previous one still waits.
`default_nettype none

module continuous_systematic_resampler #(
    parameter int MAX_POINTS    = csr_pkg::DEF_MAX_POINTS,
    parameter int MAX_PARTICLES = csr_pkg::DEF_MAX_PARTICLES
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration
    input  wire logic                             cfg_we,
    input  wire logic [csr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [csr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // weights in
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [csr_pkg::WEIGHT_W-1:0]     s_tdata,   // [31:0] weight
    // picks out
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [csr_pkg::OUT_DATA_W-1:0]        m_tdata,   // [15:0] particle_index,
                                                             // [32:16] fraction, [39:33] zero
    output logic                                  m_tlast    // last_of_run
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_BASE,
        ST_MUL_LIM,
        ST_MUL_W,
        ST_CHECK,
        ST_PREP,
        ST_SAT,
        ST_DIV
    } state_t;

    localparam int IW = csr_pkg::INDEX_W;
    localparam int FW = csr_pkg::FRAC_W;
    localparam int PW = csr_pkg::POINT_W;
    localparam int SW = csr_pkg::SUM_W;
    localparam int WW = csr_pkg::WEIGHT_W;
    localparam int PRODW = SW + PW;        // M * sum
    localparam int TGTW  = PW + WW;        // u + j * 2^32
    localparam int MWW   = WW + 6;         // M * w, M <= 64
    localparam int QW    = 16;

    state_t               state_reg, state_next;

    logic [IW-1:0]        pcount_reg, pcount_next;
    logic [PW-1:0]        pparts_reg, pparts_next;
    logic [WW-1:0]        offset_reg, offset_next;

    logic [SW-1:0]        sum_reg, sum_next;
    logic [PW-1:0]        point_reg, point_next;
    logic [IW-1:0]        seen_reg, seen_next;

    logic [WW-1:0]        w_reg, w_next;
    logic [SW-1:0]        prev_reg, prev_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic [PW-1:0]        m_reg, m_next;
    logic [IW-1:0]        n_reg, n_next;

    logic [PRODW-1:0]     base_reg, base_next;
    logic [PRODW-1:0]     limit_reg, limit_next;
    logic [MWW-1:0]       mw_reg, mw_next;
    logic [TGTW-1:0]      target_reg, target_next;
    logic [PRODW-1:0]     diff_reg, diff_next;
    logic [MWW-1:0]       rem_reg, rem_next;
    logic [QW-1:0]        quo_reg, quo_next;
    logic [3:0]           step_reg, step_next;

    logic                 pend_reg, pend_next;
    logic [IW-1:0]        pend_index_reg, pend_index_next;
    logic [FW-1:0]        pend_frac_reg, pend_frac_next;

    logic                 out_valid_reg, out_valid_next;
    logic [IW-1:0]        out_index_reg, out_index_next;
    logic [FW-1:0]        out_frac_reg, out_frac_next;
    logic                 out_last_reg, out_last_next;

    // combinational helpers
    logic [PW-1:0]        m_eff;
    logic [IW-1:0]        n_eff;
    logic [SW:0]          sum_add;
    logic [SW-1:0]        mul_b;
    logic [PRODW-1:0]     mul_p;
    logic [TGTW-1:0]      target;
    logic                 hit;
    logic                 out_free;
    logic [PRODW:0]       sub;
    logic [MWW:0]         rem_sh;
    logic                 rem_ge;

    assign m_eff = (pparts_reg > PW'(MAX_POINTS)) ? PW'(MAX_POINTS) : pparts_reg;
    assign n_eff = (pcount_reg < 16'd2) ? 16'd2 :
                   ((pcount_reg > IW'(MAX_PARTICLES)) ? IW'(MAX_PARTICLES) : pcount_reg);

    assign sum_add = {1'b0, sum_reg} + {3'b000, s_tdata};

    // shared multiplier, operand chosen by the sequencer
    always_comb
    begin
        case (state_reg)
            ST_MUL_BASE: mul_b = prev_reg;
            ST_MUL_LIM:  mul_b = sum_reg;
            default:     mul_b = {2'b00, w_reg};
        endcase
    end
    assign mul_p = {{SW{1'b0}}, m_reg} * {{PW{1'b0}}, mul_b};

    assign target   = {point_reg, offset_reg};
    assign hit      = (point_reg < m_reg) && ({{(PRODW-TGTW){1'b0}}, target} <= limit_reg);
    assign out_free = !out_valid_reg || m_tready;
    assign sub      = {{(PRODW+1-TGTW){1'b0}}, target_reg} - {1'b0, base_reg};
    assign rem_sh   = {rem_reg, 1'b0};
    assign rem_ge   = rem_sh >= {1'b0, mw_reg};

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(csr_pkg::OUT_DATA_W-IW-FW){1'b0}}, out_frac_reg, out_index_reg};
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        pcount_next     = pcount_reg;
        pparts_next     = pparts_reg;
        offset_next     = offset_reg;
        sum_next        = sum_reg;
        point_next      = point_reg;
        seen_next       = seen_reg;
        w_next          = w_reg;
        prev_next       = prev_reg;
        idx_next        = idx_reg;
        m_next          = m_reg;
        n_next          = n_reg;
        base_next       = base_reg;
        limit_next      = limit_reg;
        mw_next         = mw_reg;
        target_next     = target_reg;
        diff_next       = diff_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        step_next       = step_reg;
        pend_next       = pend_reg;
        pend_index_next = pend_index_reg;
        pend_frac_next  = pend_frac_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_index_next  = out_index_reg;
        out_frac_next   = out_frac_reg;
        out_last_next   = out_last_reg;

        if (cfg_we)
        begin
            unique case (cfg_addr)
                csr_pkg::REG_PARTICLE_COUNT:  pcount_next = cfg_wdata[IW-1:0];
                csr_pkg::REG_PARTITION_COUNT: pparts_next = cfg_wdata[PW-1:0];
                csr_pkg::REG_OFFSET_U:        offset_next = cfg_wdata[WW-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    w_next    = s_tdata;
                    prev_next = sum_reg;
                    sum_next  = sum_add[SW] ? {SW{1'b1}} : sum_add[SW-1:0];
                    idx_next  = seen_reg + 16'd1;
                    m_next    = m_eff;
                    n_next    = n_eff;
                    state_next = ST_MUL_BASE;
                end
            end
            ST_MUL_BASE:
            begin
                base_next  = mul_p;
                state_next = ST_MUL_LIM;
            end
            ST_MUL_LIM:
            begin
                limit_next = mul_p;
                state_next = ST_MUL_W;
            end
            ST_MUL_W:
            begin
                mw_next    = mul_p[MWW-1:0];
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                // release the held result once we know whether another follows
                if (!pend_reg || out_free)
                begin
                    if (pend_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_index_next = pend_index_reg;
                        out_frac_next  = pend_frac_reg;
                        out_last_next  = !hit;
                        pend_next      = 1'b0;
                    end
                    if (hit)
                    begin
                        target_next = target;
                        point_next  = point_reg + 7'd1;
                        state_next  = ST_PREP;
                    end
                    else
                    begin
                        if (idx_reg >= n_reg)
                        begin
                            sum_next   = '0;
                            point_next = '0;
                            seen_next  = '0;
                        end
                        else
                        begin
                            seen_next = idx_reg;
                        end
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_PREP:
            begin
                if (idx_reg == n_reg)
                begin
                    // last particle folds onto its neighbor at full position
                    pend_next       = 1'b1;
                    pend_index_next = n_reg - 16'd1;
                    pend_frac_next  = csr_pkg::FRAC_ONE;
                    state_next      = ST_CHECK;
                end
                else if (idx_reg == 16'd1 || w_reg == '0 || sub[PRODW])
                begin
                    pend_next       = 1'b1;
                    pend_index_next = idx_reg;
                    pend_frac_next  = '0;
                    state_next      = ST_CHECK;
                end
                else
                begin
                    diff_next  = sub[PRODW-1:0];
                    state_next = ST_SAT;
                end
            end
            ST_SAT:
            begin
                if (diff_reg >= {{(PRODW-MWW){1'b0}}, mw_reg})
                begin
                    pend_next       = 1'b1;
                    pend_index_next = idx_reg;
                    pend_frac_next  = csr_pkg::FRAC_ONE;
                    state_next      = ST_CHECK;
                end
                else
                begin
                    rem_next   = diff_reg[MWW-1:0];
                    quo_next   = '0;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // one quotient bit per cycle
                rem_next  = rem_ge ? MWW'(rem_sh - {1'b0, mw_reg}) : rem_sh[MWW-1:0];
                quo_next  = {quo_reg[QW-2:0], rem_ge};
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd15)
                begin
                    pend_next       = 1'b1;
                    pend_index_next = idx_reg;
                    pend_frac_next  = {1'b0, quo_reg[QW-2:0], rem_ge};
                    state_next      = ST_CHECK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pcount_reg    <= csr_pkg::RST_PARTICLE_COUNT;
            pparts_reg    <= csr_pkg::RST_PARTITION_COUNT;
            offset_reg    <= '0;
            sum_reg       <= '0;
            point_reg     <= '0;
            seen_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pcount_reg    <= pcount_next;
            pparts_reg    <= pparts_next;
            offset_reg    <= offset_next;
            sum_reg       <= sum_next;
            point_reg     <= point_next;
            seen_reg      <= seen_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg          <= w_next;
        prev_reg       <= prev_next;
        idx_reg        <= idx_next;
        m_reg          <= m_next;
        n_reg          <= n_next;
        base_reg       <= base_next;
        limit_reg      <= limit_next;
        mw_reg         <= mw_next;
        target_reg     <= target_next;
        diff_reg       <= diff_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        pend_index_reg <= pend_index_next;
        pend_frac_reg  <= pend_frac_next;
        out_index_reg  <= out_index_next;
        out_frac_reg   <= out_frac_next;
        out_last_reg   <= out_last_next;
    end

`ifndef SYNTH
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !pend_reg)
        else $error("result still held while accepting a weight");

    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_frac_reg <= csr_pkg::FRAC_ONE))
        else $error("fraction above one");

    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < mw_reg))
        else $error("divider remainder out of range");

    a_index_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_index_reg != 16'd0))
        else $error("zero particle index");

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK && !hit && (!pend_reg || out_free)) |=> s_tready)
        else $error("weight finished without returning to idle");
`endif

endmodule

`default_nettype wire
